// ----- rtl/cmc_pkg.sv -----
`default_nettype none

package cmc_pkg;

   localparam int MAX_RANKS = 16;
   localparam int RANK_W    = 4;
   localparam int ADDR_W    = 2 * RANK_W;
   localparam int CELLS     = MAX_RANKS * MAX_RANKS;
   localparam int CNT_W     = 32;
   localparam int NR_W      = 5;
   localparam int QDEPTH    = 4;
   localparam int Q_PTR_W   = 2;
   localparam int Q_CNT_W   = 3;

   localparam logic [NR_W-1:0] NR_RESET = NR_W'(16);
   localparam logic [NR_W-1:0] NR_MAX   = NR_W'(MAX_RANKS);

   typedef logic [RANK_W-1:0] rank_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [NR_W-1:0]   nr_type;

   typedef enum logic [1:0] {
      ACT_PAIR = 2'd0,
      ACT_ALL  = 2'd1,
      ACT_ROOT = 2'd2,
      ACT_READ = 2'd3
   } action_type;

   // one queued command for the engine
   typedef struct packed {
      action_type op;
      logic       zero;    // read outside the active square
      rank_type   src;
      rank_type   peer;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic nr_type active_ranks(input nr_type nr);
      active_ranks = (nr > NR_MAX) ? NR_MAX : nr;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cmc_if.sv -----
`default_nettype none

interface cmc_req_if;
   logic                 valid;
   logic                 ready;
   cmc_pkg::action_type  action;
   cmc_pkg::rank_type    src_rank;
   cmc_pkg::rank_type    peer_rank;

   modport source (output valid, output action, output src_rank, output peer_rank,
                   input ready);
   modport sink   (input valid, input action, input src_rank, input peer_rank,
                   output ready);
endinterface

interface cmc_rsp_if;
   logic                valid;
   logic                ready;
   cmc_pkg::count_type  count;

   modport source (output valid, output count, input ready);
   modport sink   (input valid, input count, output ready);
endinterface

`default_nettype wire

// ----- rtl/cmc_front.sv -----
`default_nettype none

module cmc_front (
   cmc_req_if.sink                    req,
   input  wire cmc_pkg::nr_type       n_act,
   input  wire cmc_pkg::q_status_type q_status,
   output logic                       q_push,
   output cmc_pkg::cmd_type           q_data
);
   import cmc_pkg::*;

   logic src_ok;
   logic peer_ok;
   logic keep;

   assign src_ok  = {1'b0, req.src_rank} < n_act;
   assign peer_ok = {1'b0, req.peer_rank} < n_act;

   // drop non-read events with a used rank out of range
   always_comb begin
      case (req.action)
         ACT_PAIR: keep = src_ok && peer_ok;
         ACT_ALL:  keep = src_ok;
         ACT_ROOT: keep = src_ok && peer_ok;
         ACT_READ: keep = 1'b1;
         default:  keep = 1'b0;
      endcase
   end

   assign req.ready   = !q_status.full;
   assign q_push      = req.valid && !q_status.full && keep;
   assign q_data.op   = req.action;
   assign q_data.zero = !(src_ok && peer_ok);
   assign q_data.src  = req.src_rank;
   assign q_data.peer = req.peer_rank;

endmodule

`default_nettype wire

// ----- rtl/cmc_fifo.sv -----
`default_nettype none

module cmc_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cmc_pkg::cmd_type push_data,
   input  wire logic             pop,
   output cmc_pkg::cmd_type      pop_data,
   output cmc_pkg::q_status_type status
);
   import cmc_pkg::*;

   cmd_type              slot_ff [QDEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   assign status.full  = cnt_ff == Q_CNT_W'(QDEPTH);
   assign status.empty = cnt_ff == '0;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cmc_engine.sv -----
`default_nettype none

module cmc_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmc_pkg::nr_type       n_act,
   input  wire cmc_pkg::q_status_type q_status,
   input  wire cmc_pkg::cmd_type      q_data,
   output logic                       q_pop,
   cmc_rsp_if.source                  rsp
);
   import cmc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RD   = 3'b010,
      ST_WR   = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   rank_type   idx_a_ff, idx_a_in;
   rank_type   idx_b_ff, idx_b_in;
   logic       second_ff, second_in;
   logic       rsp_vld_ff, rsp_vld_in;
   count_type  rsp_cnt_ff, rsp_cnt_in;

   count_type  count_mem [CELLS];
   logic [CELLS-1:0] valid_ff;
   count_type  mem_rd_ff;
   logic       vld_rd_ff;

   addr_type   addr;
   count_type  rd_data;
   count_type  inc_data;
   logic       mem_re;
   logic       mem_we;
   logic       out_free;
   nr_type     n_last;
   logic       a_last;
   logic       b_last;

   assign n_last = n_act - NR_W'(1);
   assign a_last = {1'b0, idx_a_ff} == n_last;
   assign b_last = {1'b0, idx_b_ff} == n_last;

   // cell address for the current step
   always_comb begin
      case (cmd_ff.op)
         ACT_PAIR: addr = second_ff ? {cmd_ff.peer, cmd_ff.src} : {cmd_ff.src, cmd_ff.peer};
         ACT_ALL:  addr = {idx_a_ff, idx_b_ff};
         ACT_ROOT: addr = second_ff ? {idx_a_ff, cmd_ff.peer} : {cmd_ff.peer, idx_a_ff};
         ACT_READ: addr = {cmd_ff.src, cmd_ff.peer};
         default:  addr = '0;
      endcase
   end

   // never-written cells read as zero
   assign rd_data  = vld_rd_ff ? mem_rd_ff : '0;
   assign inc_data = (rd_data == '1) ? rd_data : rd_data + CNT_W'(1);
   assign out_free = !rsp_vld_ff || rsp.ready;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_a_in   = idx_a_ff;
      idx_b_in   = idx_b_ff;
      second_in  = second_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      rsp_cnt_in = rsp_cnt_ff;
      q_pop      = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_data;
               idx_a_in  = '0;
               idx_b_in  = '0;
               second_in = 1'b0;
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            mem_re   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            if (cmd_ff.op == ACT_READ) begin
               if (out_free) begin
                  rsp_vld_in = 1'b1;
                  rsp_cnt_in = cmd_ff.zero ? '0 : rd_data;
                  state_in   = ST_IDLE;
               end
            end else begin
               mem_we   = 1'b1;
               state_in = ST_RD;
               case (cmd_ff.op)
                  ACT_PAIR: begin
                     second_in = 1'b1;
                     if (second_ff) begin
                        state_in = ST_IDLE;
                     end
                  end
                  ACT_ALL: begin
                     if (b_last) begin
                        idx_b_in = '0;
                        idx_a_in = idx_a_ff + RANK_W'(1);
                        if (a_last) begin
                           state_in = ST_IDLE;
                        end
                     end else begin
                        idx_b_in = idx_b_ff + RANK_W'(1);
                     end
                  end
                  ACT_ROOT: begin
                     second_in = !second_ff;
                     if (second_ff) begin
                        idx_a_in = idx_a_ff + RANK_W'(1);
                        if (a_last) begin
                           state_in = ST_IDLE;
                        end
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (mem_we) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_a_ff   <= idx_a_in;
      idx_b_ff   <= idx_b_in;
      second_ff  <= second_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[addr] <= inc_data;
      end
      if (mem_re) begin
         mem_rd_ff <= count_mem[addr];
         vld_rd_ff <= valid_ff[addr];
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.count = rsp_cnt_ff;

endmodule

`default_nettype wire

// ----- rtl/comm_matrix_counter.sv -----
// channel   dir  handshake         word
// req_chan  in   valid/ready       action, src_rank, peer_rank
// rsp_chan  out  valid/ready       count (read actions only)
// csr_*     in   csr_wr_en only    num_ranks (5 bits)
//
// the engine does one read-modify-write of the counter ram per cell, a read
// state then a write state, after an idle state that pops its queue; a read
// action reads one cell and may wait on rsp; pairwise touches 2 cells, rooted
// collective 2*n, all-to-all n*n (n active ranks); the counter ram is single-port
// reset is synchronous; per-cell valid bits clear the matrix at once, no sweep
// a four-entry queue lets req words be taken while the engine walks or rsp stalls
`default_nettype none

module comm_matrix_counter (
   input  wire logic              clock,
   input  wire logic              reset,
   cmc_req_if.sink                req_chan,
   cmc_rsp_if.source              rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire cmc_pkg::nr_type   csr_wr_data
);
   import cmc_pkg::*;

   // num_ranks register, saturated view feeds both halves
   nr_type        nr_ff;
   nr_type        n_act;

   // queue between the classifying front and the counting engine
   logic          q_push;
   logic          q_pop;
   cmd_type       q_push_data;
   cmd_type       q_pop_data;
   q_status_type  q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ff <= NR_RESET;
      end else if (csr_wr_en) begin
         nr_ff <= csr_wr_data;
      end
   end

   assign n_act = active_ranks(nr_ff);

   // front: range checks, drops dead events, flags out-of-range reads
   cmc_front u_front (
      .req      (req_chan),
      .n_act    (n_act),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   cmc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // engine: walks cells, owns the counter ram and the rsp register
   cmc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .n_act    (n_act),
      .q_status (q_status),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_nr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> nr_ff == $past(csr_wr_data))
      else $error("num_ranks write lost");

   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_act <= NR_MAX)
      else $error("active rank count above maximum");
`endif

endmodule

`default_nettype wire
